FILE: rtl/pio_seq_pkg.sv
// Shared types and constants for the parallel I/O hand-off sequencer.
package pio_seq_pkg;

    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W   = 4;
    localparam int SIG_W     = 5;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [LIMIT_W-1:0] t_limit;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_REQ_ON    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_READY_ON  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_CARRIER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_READY_OFF = 2'd3;

    localparam t_limit RST_LIMIT_REQ_ON    = 16'd200;
    localparam t_limit RST_LIMIT_READY_ON  = 16'd200;
    localparam t_limit RST_LIMIT_CARRIER   = 16'd6000;
    localparam t_limit RST_LIMIT_READY_OFF = 16'd200;

    // sequence steps
    localparam t_phase PH_IDLE           = 4'd0;
    localparam t_phase PH_RAISE_CS       = 4'd1;
    localparam t_phase PH_RAISE_VALID    = 4'd2;
    localparam t_phase PH_WAIT_REQ       = 4'd3;
    localparam t_phase PH_RAISE_TR       = 4'd4;
    localparam t_phase PH_WAIT_READY     = 4'd5;
    localparam t_phase PH_RAISE_BUSY     = 4'd6;
    localparam t_phase PH_WAIT_CARRIER   = 4'd7;
    localparam t_phase PH_DROP_BUSY      = 4'd8;
    localparam t_phase PH_COMPLETE       = 4'd9;
    localparam t_phase PH_SPARE_A        = 4'd10;
    localparam t_phase PH_WAIT_READY_OFF = 4'd11;
    localparam t_phase PH_RELEASE        = 4'd12;
    localparam t_phase PH_DONE           = 4'd13;
    localparam t_phase PH_ALARM          = 4'd14;
    localparam t_phase PH_SPARE_B        = 4'd15;

    // bit positions in the signal level vector
    localparam int SIG_VALID = 0;
    localparam int SIG_CS    = 1;
    localparam int SIG_TR    = 2;
    localparam int SIG_BUSY  = 3;
    localparam int SIG_COMPT = 4;

    typedef struct packed {
        t_limit req_on;
        t_limit ready_on;
        t_limit carrier;
        t_limit ready_off;
    } t_limits;

    typedef struct packed {
        logic load_start_n;
        logic unload_start_n;
        logic load_request_n;
        logic unload_request_n;
        logic partner_ready_n;
    } t_in_item;

    typedef struct packed {
        logic   valid_out;
        logic   carrier_select_out;
        logic   transfer_request_out;
        logic   busy_out;
        logic   complete_out;
        t_phase phase_out;
        logic   active_out;
    } t_out_item;

endpackage

FILE: rtl/pio_seq_if.sv
// Valid/ready channel interfaces for sequencer input and result items.
interface pio_seq_in_if;
    logic valid;
    logic ready;
    logic load_start_n;
    logic unload_start_n;
    logic load_request_n;
    logic unload_request_n;
    logic partner_ready_n;

    modport source (
        output valid, load_start_n, unload_start_n, load_request_n,
               unload_request_n, partner_ready_n,
        input  ready
    );
    modport sink (
        input  valid, load_start_n, unload_start_n, load_request_n,
               unload_request_n, partner_ready_n,
        output ready
    );
endinterface

interface pio_seq_out_if;
    logic       valid;
    logic       ready;
    logic       valid_out;
    logic       carrier_select_out;
    logic       transfer_request_out;
    logic       busy_out;
    logic       complete_out;
    logic [3:0] phase_out;
    logic       active_out;

    modport source (
        output valid, valid_out, carrier_select_out, transfer_request_out,
               busy_out, complete_out, phase_out, active_out,
        input  ready
    );
    modport sink (
        input  valid, valid_out, carrier_select_out, transfer_request_out,
               busy_out, complete_out, phase_out, active_out,
        output ready
    );
endinterface

FILE: rtl/pio_seq_cfg.sv
// Timeout limit registers with a plain write port.
module pio_seq_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [pio_seq_pkg::CFG_IDX_W-1:0]  i_idx,
    input  logic [pio_seq_pkg::LIMIT_W-1:0]    i_data,
    output pio_seq_pkg::t_limits               o_limits
);
    import pio_seq_pkg::*;

    t_limits r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.req_on    <= RST_LIMIT_REQ_ON;
            r_limits.ready_on  <= RST_LIMIT_READY_ON;
            r_limits.carrier   <= RST_LIMIT_CARRIER;
            r_limits.ready_off <= RST_LIMIT_READY_OFF;
        end else if (i_we) begin
            case (i_idx)
                CFG_LIMIT_REQ_ON:    r_limits.req_on    <= i_data;
                CFG_LIMIT_READY_ON:  r_limits.ready_on  <= i_data;
                CFG_LIMIT_CARRIER:   r_limits.carrier   <= i_data;
                CFG_LIMIT_READY_OFF: r_limits.ready_off <= i_data;
                default: ;
            endcase
        end
    end

    assign o_limits = r_limits;
endmodule

FILE: rtl/pio_seq_core.sv
// Sequencer state registers and the one-tick next-state logic.
module pio_seq_core #(
    parameter int TickBits = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  pio_seq_pkg::t_in_item  i_item,
    input  pio_seq_pkg::t_limits   i_limits,
    output pio_seq_pkg::t_out_item o_result
);
    import pio_seq_pkg::*;

    localparam int CmpW = (TickBits > LIMIT_W) ? TickBits : LIMIT_W;

    t_phase              r_phase,  n_phase;
    logic [TickBits-1:0] r_ticks,  n_ticks;
    logic                r_active, n_active;
    logic [SIG_W-1:0]    r_sig,    n_sig;

    logic                load_on, unload_on, lreq_on, ureq_on, ready_on;
    logic [TickBits-1:0] ticks_inc;
    t_limit              cur_limit;
    logic                timeout;

    assign load_on   = !i_item.load_start_n;
    assign unload_on = !i_item.unload_start_n;
    assign lreq_on   = !i_item.load_request_n;
    assign ureq_on   = !i_item.unload_request_n;
    assign ready_on  = !i_item.partner_ready_n;

    // limit of the wait step in progress; count wraps at the counter width
    always_comb begin
        case (r_phase)
            PH_WAIT_REQ:       cur_limit = i_limits.req_on;
            PH_WAIT_READY:     cur_limit = i_limits.ready_on;
            PH_WAIT_CARRIER:   cur_limit = i_limits.carrier;
            PH_WAIT_READY_OFF: cur_limit = i_limits.ready_off;
            default:           cur_limit = i_limits.req_on;
        endcase
    end

    assign ticks_inc = r_ticks + 1'b1;
    assign timeout   = CmpW'(ticks_inc) > CmpW'(cur_limit);

    always_comb begin
        n_phase  = r_phase;
        n_ticks  = r_ticks;
        n_active = r_active;
        n_sig    = r_sig;
        if (i_accept) begin
            if (load_on || unload_on) begin
                if (!r_active) begin
                    n_active = 1'b1;
                    n_ticks  = '0;
                    n_phase  = PH_RAISE_CS;
                end
            end else if (r_active) begin
                n_active = 1'b0;
                n_sig    = '0;
            end

            if (n_active) begin
                case (n_phase)
                    PH_RAISE_CS: begin
                        if (r_sig[SIG_CS]) n_phase = PH_RAISE_VALID;
                        else n_sig[SIG_CS] = 1'b1;
                    end
                    PH_RAISE_VALID: begin
                        if (r_sig[SIG_VALID]) n_phase = PH_WAIT_REQ;
                        else n_sig[SIG_VALID] = 1'b1;
                    end
                    PH_WAIT_REQ: begin
                        if ((load_on && lreq_on) || (unload_on && ureq_on))
                            n_phase = PH_RAISE_TR;
                        n_ticks = ticks_inc;
                        if (timeout) n_phase = PH_ALARM;
                    end
                    PH_RAISE_TR: begin
                        if (r_sig[SIG_TR]) begin
                            n_ticks = '0;
                            n_phase = PH_WAIT_READY;
                        end else begin
                            n_sig[SIG_TR] = 1'b1;
                        end
                    end
                    PH_WAIT_READY: begin
                        if (ready_on) n_phase = PH_RAISE_BUSY;
                        n_ticks = ticks_inc;
                        if (timeout) n_phase = PH_ALARM;
                    end
                    PH_RAISE_BUSY: begin
                        if (r_sig[SIG_BUSY]) begin
                            n_ticks = '0;
                            n_phase = PH_WAIT_CARRIER;
                        end else begin
                            n_sig[SIG_BUSY] = 1'b1;
                        end
                    end
                    PH_WAIT_CARRIER: begin
                        if ((load_on && !lreq_on) || (unload_on && !ureq_on))
                            n_phase = PH_DROP_BUSY;
                        n_ticks = ticks_inc;
                        if (timeout) n_phase = PH_ALARM;
                    end
                    PH_DROP_BUSY: begin
                        if (r_sig[SIG_BUSY]) n_sig[SIG_BUSY] = 1'b0;
                        else n_phase = PH_COMPLETE;
                    end
                    PH_COMPLETE: begin
                        if (r_sig[SIG_TR]) begin
                            n_sig[SIG_TR] = 1'b0;
                        end else if (!r_sig[SIG_COMPT]) begin
                            n_sig[SIG_COMPT] = 1'b1;
                        end else begin
                            n_ticks = '0;
                            n_phase = PH_WAIT_READY_OFF;
                        end
                    end
                    PH_WAIT_READY_OFF: begin
                        if (!ready_on) n_phase = PH_RELEASE;
                        n_ticks = ticks_inc;
                        if (timeout) n_phase = PH_ALARM;
                    end
                    PH_RELEASE: begin
                        if (r_sig[SIG_VALID] || r_sig[SIG_COMPT] || r_sig[SIG_CS]) begin
                            n_sig[SIG_VALID] = 1'b0;
                            n_sig[SIG_COMPT] = 1'b0;
                            n_sig[SIG_CS]    = 1'b0;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DONE: ;
                    // alarm and the unused codes hold every line off
                    default: n_sig = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_ticks  <= '0;
            r_active <= 1'b0;
            r_sig    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_ticks  <= n_ticks;
            r_active <= n_active;
            r_sig    <= n_sig;
        end
    end

    always_comb begin
        o_result.valid_out            = n_sig[SIG_VALID];
        o_result.carrier_select_out   = n_sig[SIG_CS];
        o_result.transfer_request_out = n_sig[SIG_TR];
        o_result.busy_out             = n_sig[SIG_BUSY];
        o_result.complete_out         = n_sig[SIG_COMPT];
        o_result.phase_out            = n_phase;
        o_result.active_out           = n_active;
    end
endmodule

FILE: rtl/pio_seq_oreg.sv
// Result register that decouples the input handshake from the output side.
module pio_seq_oreg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_accept,
    input  pio_seq_pkg::t_out_item i_result,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output pio_seq_pkg::t_out_item o_item
);
    import pio_seq_pkg::*;

    logic      r_valid, n_valid;
    t_out_item r_item;

    assign o_in_ready = !r_valid || i_out_ready;
    assign o_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_accept) n_valid = 1'b1;
        else if (i_out_ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_item      = r_item;
endmodule

FILE: rtl/parallel_io_handoff_active_sequencer_top.sv
// Top level: active-side carrier hand-off sequencer, one item per tick.
// A result item is registered and valid the cycle after its input item is accepted.
// Throughput: one item per cycle while the result side takes results; the state update is a single registered step.
// The input side keeps taking items while a result waits, as long as that
// result is taken in the same cycle (result register with ready pass-through).
// Reset (i_rst_n low, synchronous): step idle, session off, all lines off,
// tick counter zero, limits back to 200/200/6000/200 ticks.
module parallel_io_handoff_active_sequencer_top #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pio_seq_in_if.sink                        i_in,
    pio_seq_out_if.source                     o_out,
    input  logic                              i_cfg_we,
    input  logic [pio_seq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pio_seq_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import pio_seq_pkg::*;

    t_limits   limits;
    t_in_item  in_item;
    t_out_item result;
    t_out_item out_item;
    logic      accept;
    logic      in_ready;
    logic      out_valid;

    // Pack the input lines; all handshake lines are active low.
    always_comb begin
        in_item.load_start_n     = i_in.load_start_n;
        in_item.unload_start_n   = i_in.unload_start_n;
        in_item.load_request_n   = i_in.load_request_n;
        in_item.unload_request_n = i_in.unload_request_n;
        in_item.partner_ready_n  = i_in.partner_ready_n;
    end

    // Four timeout limits; to be written only while the block is idle, which the block does not enforce.
    pio_seq_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (i_cfg_we),
        .i_idx    (i_cfg_idx),
        .i_data   (i_cfg_data),
        .o_limits (limits)
    );

    // Step sequencer: advances only on an accepted item (one tick).
    pio_seq_core #(
        .TickBits (TICK_COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (in_item),
        .i_limits (limits),
        .o_result (result)
    );

    // Result register; its ready drives the input channel's ready.
    pio_seq_oreg u_oreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_accept    (accept),
        .i_result    (result),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_item      (out_item)
    );

    assign i_in.ready                 = in_ready;
    assign o_out.valid                = out_valid;
    assign o_out.valid_out            = out_item.valid_out;
    assign o_out.carrier_select_out   = out_item.carrier_select_out;
    assign o_out.transfer_request_out = out_item.transfer_request_out;
    assign o_out.busy_out             = out_item.busy_out;
    assign o_out.complete_out         = out_item.complete_out;
    assign o_out.phase_out            = out_item.phase_out;
    assign o_out.active_out           = out_item.active_out;
endmodule

FILE: rtl/pio_seq_chk.sv
// Port-level checker for the hand-off sequencer, bound to the top level.
module pio_seq_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_valid_out,
    input logic                        i_cs_out,
    input logic                        i_tr_out,
    input logic                        i_busy_out,
    input logic                        i_compt_out,
    input pio_seq_pkg::t_phase         i_phase_out,
    input logic                        i_active_out
);
    import pio_seq_pkg::*;

    // a pending result is held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_phase_out))
        else $error("result dropped or changed while stalled");

    // no line is driven outside a session
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_active_out |->
            !(i_valid_out || i_cs_out || i_tr_out || i_busy_out || i_compt_out))
        else $error("line on without an active session");

    // BUSY only inside CS, VALID and TR_REQ
    a_busy_nest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_busy_out |-> i_tr_out && i_valid_out && i_cs_out)
        else $error("BUSY without CS, VALID and TR_REQ");

    // COMPT never overlaps BUSY or TR_REQ
    a_compt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_compt_out |-> !i_busy_out && !i_tr_out)
        else $error("COMPT overlaps BUSY or TR_REQ");

    // unused step codes are never reached
    a_phase_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_phase_out != PH_SPARE_A && i_phase_out != PH_SPARE_B)
        else $error("unused step code reported");
endmodule

bind parallel_io_handoff_active_sequencer_top pio_seq_chk u_pio_seq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_valid_out  (o_out.valid_out),
    .i_cs_out     (o_out.carrier_select_out),
    .i_tr_out     (o_out.transfer_request_out),
    .i_busy_out   (o_out.busy_out),
    .i_compt_out  (o_out.complete_out),
    .i_phase_out  (o_out.phase_out),
    .i_active_out (o_out.active_out)
);

FILE: verif/handoff_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class: line-level predictor of the hand-off sequencer and result checks.
package handoff_check_pkg;
    import pio_seq_pkg::*;

    class handoff_scoreboard;
        t_limits           lim;
        t_phase            ph;
        logic [15:0]       ticks;
        bit                active;
        logic [SIG_W-1:0]  lines;
        t_out_item         pending_levels[$];
        int                errors;
        int                results_seen;

        function new();
            lim.req_on    = RST_LIMIT_REQ_ON;
            lim.ready_on  = RST_LIMIT_READY_ON;
            lim.carrier   = RST_LIMIT_CARRIER;
            lim.ready_off = RST_LIMIT_READY_OFF;
            ph            = PH_IDLE;
            ticks         = '0;
            active        = 1'b0;
            lines         = '0;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, t_limit v);
            case (idx)
                CFG_LIMIT_REQ_ON:    lim.req_on    = v;
                CFG_LIMIT_READY_ON:  lim.ready_on  = v;
                CFG_LIMIT_CARRIER:   lim.carrier   = v;
                CFG_LIMIT_READY_OFF: lim.ready_off = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction

        // count one tick of a wait; passing the limit wins over the awaited event
        function void count_tick(t_limit limit);
            ticks = ticks + 16'd1;
            if (ticks > limit) ph = PH_ALARM;
        endfunction

        function bit raise_or_pass(int b);
            if (!lines[b]) begin
                lines[b] = 1'b1;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void run_step(bit ld, bit ul, bit lr, bit ur, bit rd);
            case (ph)
                PH_RAISE_CS:    if (raise_or_pass(SIG_CS)) ph = PH_RAISE_VALID;
                PH_RAISE_VALID: if (raise_or_pass(SIG_VALID)) ph = PH_WAIT_REQ;
                PH_WAIT_REQ: begin
                    if ((ld && lr) || (ul && ur)) ph = PH_RAISE_TR;
                    count_tick(lim.req_on);
                end
                PH_RAISE_TR: if (raise_or_pass(SIG_TR)) begin
                    ticks = '0;
                    ph    = PH_WAIT_READY;
                end
                PH_WAIT_READY: begin
                    if (rd) ph = PH_RAISE_BUSY;
                    count_tick(lim.ready_on);
                end
                PH_RAISE_BUSY: if (raise_or_pass(SIG_BUSY)) begin
                    ticks = '0;
                    ph    = PH_WAIT_CARRIER;
                end
                PH_WAIT_CARRIER: begin
                    if ((ld && !lr) || (ul && !ur)) ph = PH_DROP_BUSY;
                    count_tick(lim.carrier);
                end
                PH_DROP_BUSY: begin
                    if (lines[SIG_BUSY]) lines[SIG_BUSY] = 1'b0;
                    else ph = PH_COMPLETE;
                end
                PH_COMPLETE: begin
                    if (lines[SIG_TR]) lines[SIG_TR] = 1'b0;
                    else if (!lines[SIG_COMPT]) lines[SIG_COMPT] = 1'b1;
                    else begin
                        ticks = '0;
                        ph    = PH_WAIT_READY_OFF;
                    end
                end
                PH_WAIT_READY_OFF: begin
                    if (!rd) ph = PH_RELEASE;
                    count_tick(lim.ready_off);
                end
                PH_RELEASE: begin
                    if (lines[SIG_VALID] || lines[SIG_COMPT] || lines[SIG_CS]) begin
                        lines[SIG_VALID] = 1'b0;
                        lines[SIG_COMPT] = 1'b0;
                        lines[SIG_CS]    = 1'b0;
                    end else begin
                        ph = PH_DONE;
                    end
                end
                PH_DONE: ;
                // alarm and the spare steps hold every line off
                default: lines = '0;
            endcase
        endfunction

        // one accepted tick: update the state and queue the line levels it gives
        function void accept_tick(t_in_item it);
            t_out_item e;
            bit ld, ul, lr, ur, rd;
            ld = !it.load_start_n;
            ul = !it.unload_start_n;
            lr = !it.load_request_n;
            ur = !it.unload_request_n;
            rd = !it.partner_ready_n;
            if (ld || ul) begin
                if (!active) begin
                    active = 1'b1;
                    ticks  = '0;
                    ph     = PH_RAISE_CS;
                end
            end else if (active) begin
                active = 1'b0;
                lines  = '0;
            end
            if (active) run_step(ld, ul, lr, ur, rd);
            e.valid_out            = lines[SIG_VALID];
            e.carrier_select_out   = lines[SIG_CS];
            e.transfer_request_out = lines[SIG_TR];
            e.busy_out             = lines[SIG_BUSY];
            e.complete_out         = lines[SIG_COMPT];
            e.phase_out            = ph;
            e.active_out           = active;
            pending_levels.push_back(e);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch at result %0d: %s", $time, results_seen, msg);
            errors++;
        endtask

        task cmp_field(string name, logic [PHASE_W-1:0] got, logic [PHASE_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_levels(t_out_item got);
            t_out_item want;
            results_seen++;
            if (pending_levels.size() == 0) begin
                report("result with no item waiting");
                return;
            end
            want = pending_levels.pop_front();
            cmp_field("valid_out", PHASE_W'(got.valid_out), PHASE_W'(want.valid_out));
            cmp_field("carrier_select_out", PHASE_W'(got.carrier_select_out),
                      PHASE_W'(want.carrier_select_out));
            cmp_field("transfer_request_out", PHASE_W'(got.transfer_request_out),
                      PHASE_W'(want.transfer_request_out));
            cmp_field("busy_out", PHASE_W'(got.busy_out), PHASE_W'(want.busy_out));
            cmp_field("complete_out", PHASE_W'(got.complete_out),
                      PHASE_W'(want.complete_out));
            cmp_field("phase_out", got.phase_out, want.phase_out);
            cmp_field("active_out", PHASE_W'(got.active_out), PHASE_W'(want.active_out));
        endtask
    endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench: drives partner sessions into the hand-off sequencer and checks each tick.
module tb_top;
    import pio_seq_pkg::*;
    import handoff_check_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    pio_seq_in_if  in_ch();
    pio_seq_out_if out_ch();

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [LIMIT_W-1:0]   cfg_data;

    parallel_io_handoff_active_sequencer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    handoff_scoreboard sb;

    // Knobs shaping the partner behavior of the current phase of the run.
    int eager_pct;    // chance per tick that the partner answers the awaited event
    int noise_pct;    // chance that an item is replaced by random line levels
    int abort_pct;    // chance that the start is released in mid-session
    int release_pct;  // chance per tick of releasing start once done or in alarm
    bit no_idle;      // both sides run flat out
    bit hold_off_req; // asks the receiver for one long stall

    // Partner-side session state: which start is held, and the line levels it drives.
    bit sess_on, sess_load, sess_unload, req_on, rdy_on;
    int gap_left;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic void end_session();
        sess_on  = 1'b0;
        req_on   = 1'b0;
        rdy_on   = 1'b0;
        gap_left = $urandom_range(4);
    endfunction

    // Next item from a partner that reacts to the predicted step. The first tick
    // of a session sees the old step still, so reactions wait for the session flag.
    function automatic t_in_item next_item();
        t_in_item it;
        int       kind;
        if (!sess_on) begin
            if (gap_left > 0) begin
                gap_left--;
            end else begin
                sess_on     = 1'b1;
                kind        = $urandom_range(9);
                sess_load   = (kind < 5) || (kind == 9);  // kind 9: both starts held
                sess_unload = (kind >= 5);
                req_on      = 1'b0;
                rdy_on      = 1'b0;
            end
        end else if (sb.active) begin
            case (sb.ph)
                PH_WAIT_REQ:       if (chance(eager_pct)) req_on = 1'b1;
                PH_WAIT_READY:     if (chance(eager_pct)) rdy_on = 1'b1;
                PH_WAIT_CARRIER:   if (chance(eager_pct)) req_on = 1'b0;
                PH_WAIT_READY_OFF: if (chance(eager_pct)) rdy_on = 1'b0;
                PH_DONE, PH_ALARM: if (chance(release_pct)) end_session();
                default: ;
            endcase
            if (sess_on && chance(abort_pct)) end_session();
        end
        it.load_start_n   = !(sess_on && sess_load);
        it.unload_start_n = !(sess_on && sess_unload);
        if (!sess_on) begin
            // between sessions the partner lines wander freely
            it.load_request_n   = 1'($urandom_range(1));
            it.unload_request_n = 1'($urandom_range(1));
            it.partner_ready_n  = 1'($urandom_range(1));
        end else begin
            it.load_request_n   = !(req_on && sess_load);
            it.unload_request_n = !(req_on && sess_unload);
            it.partner_ready_n  = !rdy_on;
        end
        if (chance(noise_pct)) it = t_in_item'($urandom_range(31));
        return it;
    endfunction

    // Offer one item, starting at a falling edge; returns at the falling edge after
    // it is taken. Valid stays high straight into the next item when no gap falls.
    task automatic send_item(t_in_item it);
        while (!no_idle && $urandom_range(99) < 22) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.load_start_n     <= it.load_start_n;
        in_ch.unload_start_n   <= it.unload_start_n;
        in_ch.load_request_n   <= it.load_request_n;
        in_ch.unload_request_n <= it.unload_request_n;
        in_ch.partner_ready_n  <= it.partner_ready_n;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.accept_tick(it);
        @(negedge i_clk);
    endtask

    task automatic run_items(int n);
        repeat (n) send_item(next_item());
    endtask

    // Stop offering and wait until every tick has its result back, so the block is idle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Write all four limits, one per cycle, only while idle.
    task automatic write_limits(t_limit l0, t_limit l1, t_limit l2, t_limit l3);
        t_limit vals[4];
        vals = '{l0, l1, l2, l3};
        for (int k = 0; k < 4; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(k);
            cfg_data <= vals[k];
            sb.set_limit(CFG_IDX_W'(k), vals[k]);
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_knobs(int eager, int noise, int abort_chance, int rel);
        eager_pct   = eager;
        noise_pct   = noise;
        abort_pct   = abort_chance;
        release_pct = rel;
    endtask

    // Result side: random stalls, plus one long hold-off on request while the
    // sender keeps offering, so the result register fills and input stalls.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (60) @(negedge i_clk);
            end else begin
                out_ch.ready <= no_idle || ($urandom_range(99) >= 22);
            end
        end
    end

    // Result monitor: sampled at the rising edge, before any update of that edge.
    always @(posedge i_clk) begin
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.valid_out            = out_ch.valid_out;
            got.carrier_select_out   = out_ch.carrier_select_out;
            got.transfer_request_out = out_ch.transfer_request_out;
            got.busy_out             = out_ch.busy_out;
            got.complete_out         = out_ch.complete_out;
            got.phase_out            = out_ch.phase_out;
            got.active_out           = out_ch.active_out;
            sb.check_levels(got);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_in_item it;
        int       guard;
        sb                     = new();
        i_rst_n                = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.load_start_n     = 1'b1;
        in_ch.unload_start_n   = 1'b1;
        in_ch.load_request_n   = 1'b1;
        in_ch.unload_request_n = 1'b1;
        in_ch.partner_ready_n  = 1'b1;
        cfg_we                 = 1'b0;
        cfg_idx                = CFG_LIMIT_REQ_ON;
        cfg_data               = '0;
        no_idle                = 1'b0;
        hold_off_req           = 1'b0;
        sess_on                = 1'b0;
        sess_load              = 1'b0;
        sess_unload            = 1'b0;
        req_on                 = 1'b0;
        rdy_on                 = 1'b0;
        gap_left               = 0;
        set_knobs(100, 0, 0, 100);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- Directed part, reset limits ----
        // Idle tick: all lines released.
        send_item(t_in_item'(5'b11111));
        // Full load session with a partner that answers at once, then release.
        sess_on     = 1'b1;
        sess_load   = 1'b1;
        sess_unload = 1'b0;
        run_items(21);
        end_session();
        send_item(t_in_item'(5'b11111));
        // Unload start while only the load request is on: the request must not count.
        it.load_start_n     = 1'b1;
        it.unload_start_n   = 1'b0;
        it.load_request_n   = 1'b0;
        it.unload_request_n = 1'b1;
        it.partner_ready_n  = 1'b1;
        repeat (6) send_item(it);
        // Release in mid-session, then every line on: restart with both starts.
        send_item(t_in_item'(5'b11111));
        send_item(t_in_item'(5'b00000));
        send_item(t_in_item'(5'b11111));
        drain();
        gap_left = 0;

        // ---- Random part, one phase per limit setting ----
        // Reset limits, lively partner.
        set_knobs(40, 5, 1, 30);
        run_items(160);
        drain();

        // Zero limits: every wait times out, even on the tick its event is seen.
        write_limits(16'd0, 16'd0, 16'd0, 16'd0);
        set_knobs(50, 5, 1, 30);
        run_items(160);
        drain();

        // Limits one below the largest value, no idling on either side.
        write_limits(16'd65534, 16'd65534, 16'd65534, 16'd65534);
        set_knobs(30, 3, 1, 30);
        no_idle = 1'b1;
        run_items(160);
        drain();
        no_idle = 1'b0;

        // Tight limits with a slow partner; one long receiver stall halfway.
        write_limits(t_limit'($urandom_range(8, 1)), t_limit'($urandom_range(8, 1)),
                     t_limit'($urandom_range(8, 1)), t_limit'($urandom_range(8, 1)));
        set_knobs(20, 5, 1, 30);
        run_items(80);
        hold_off_req = 1'b1;
        run_items(80);
        drain();

        // Limits anywhere in range; the sender pauses for a full drain halfway.
        write_limits(t_limit'($urandom_range(65534)), t_limit'($urandom_range(65534)),
                     t_limit'($urandom_range(65534)), t_limit'($urandom_range(65534)));
        set_knobs(40, 5, 1, 30);
        run_items(80);
        drain();
        run_items(80);
        drain();

        // Moderate limits, sluggish partner and more aborts.
        write_limits(t_limit'($urandom_range(24, 2)), t_limit'($urandom_range(24, 2)),
                     t_limit'($urandom_range(24, 2)), t_limit'($urandom_range(24, 2)));
        set_knobs(10, 2, 2, 30);
        run_items(160);

        // ---- Wind-down: bounded wait for the last results ----
        in_ch.valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
